// ----- rtl/core/mscfd_pkg.sv -----
// ----------------------------------------------------------------------------
// mscfd_pkg
// Types, codes and constants of the motor/servo command frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package mscfd_pkg;

	localparam int FRAME_BYTES_DEF = 10;
	localparam int STATUS_LEN      = 14;
	localparam int DEC_BYTES       = 10;

	localparam logic [7:0] CMD_MOTOR_DUAL = 8'h01;
	localparam logic [7:0] CMD_MOTOR_ONE  = 8'h02;
	localparam logic [7:0] CMD_MOTOR_TWO  = 8'h03;
	localparam logic [7:0] CMD_SERVO_DUAL = 8'h10;
	localparam logic [7:0] CMD_SERVO_ONE  = 8'h11;
	localparam logic [7:0] CMD_SERVO_TWO  = 8'h12;
	localparam logic [7:0] CMD_RESET_ENC  = 8'h20;
	localparam logic [7:0] CMD_STATUS     = 8'h30;
	localparam logic [7:0] ERR_BYTE       = 8'hFF;

	localparam logic [7:0] MODE_SPEED = 8'd0;
	localparam logic [7:0] MODE_POS16 = 8'd1;
	localparam logic [7:0] MODE_POS32 = 8'd2;

	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_READ   = 2'd1,
		OP_STATUS = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		KIND_MOTOR_DUAL = 3'd0,
		KIND_MOTOR_ONE  = 3'd1,
		KIND_MOTOR_TWO  = 3'd2,
		KIND_SERVO_DUAL = 3'd3,
		KIND_SERVO_ONE  = 3'd4,
		KIND_SERVO_TWO  = 3'd5,
		KIND_RESET_ENC  = 3'd6,
		KIND_READ       = 3'd7
	} kind_t;

	typedef struct packed {
		logic [7:0]         read_data;
		logic signed [7:0]  second_angle;
		logic signed [7:0]  first_angle;
		logic signed [31:0] second_long;
		logic signed [15:0] second_short;
		logic signed [31:0] first_long;
		logic signed [15:0] first_short;
		logic [7:0]         ctrl_mode;
	} result_t;

endpackage

`default_nettype wire

// ----- rtl/core/motor_servo_command_frame_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// motor_servo_command_frame_decoder_unit
// Buffers write frames, stores motor status updates, decodes motor/servo commands on frame end and answers
// read requests with the big-endian status of both motors or an error byte.
// ----------------------------------------------------------------------------
// channel | dir | tdata                                   | tuser          | tlast
// s_*     | in  | rx_byte, status_position, speed, mode   | op, motor sel  | frame_end
// m_*     | out | ctrl_mode .. read_data (128 bits)       | out_kind       | last_of_run
//
// One word per cycle, unless m_tready or a status read stalls it, through an input stage and a result register.
// A status read holds the input stage until all 14 status bytes have been sent, one byte per word.
// Reset clears frame count, last command, motor status and both valids.
// Stalls on m_tready propagate to s_tready within the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_servo_command_frame_decoder_unit #(
	parameter int FRAME_BYTES = mscfd_pkg::FRAME_BYTES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// rx_byte[7:0], status_position[39:8], status_speed[55:40], status_mode[63:56]
	input  wire logic [63:0]  s_tdata,
	// op[1:0], status_motor[2]
	input  wire logic [2:0]   s_tuser,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// ctrl_mode[7:0], first_short[23:8], first_long[55:24], second_short[71:56],
	// second_long[103:72], first_angle[111:104], second_angle[119:112],
	// read_data[127:120]
	output logic [127:0]      m_tdata,
	// out_kind[2:0]
	output logic [2:0]        m_tuser,
	output logic              m_tlast
);
	import mscfd_pkg::*;

	localparam int CW = $clog2(FRAME_BYTES + 1);
	localparam int IW = $clog2(FRAME_BYTES);
	localparam int RW = $clog2(STATUS_LEN);

	// input stage
	logic               s1_valid_q;
	op_t                op_s1;
	logic [7:0]         byte_s1;
	logic               end_s1;
	logic               sel_s1;
	logic [31:0]        pos_s1;
	logic [15:0]        spd_s1;
	logic [7:0]         mode_s1;

	// state
	logic [7:0]         buf_q [FRAME_BYTES];
	logic [CW-1:0]      cnt_q;
	logic [7:0]         last_cmd_q;
	logic [31:0]        mpos_q [2];
	logic [15:0]        mspd_q [2];
	logic [7:0]         mmode_q [2];
	logic [RW-1:0]      rd_idx_q;

	// result register
	logic               m_valid_q;
	result_t            res_q;
	kind_t              kind_q;
	logic               last_q;

	logic [7:0]         nb [DEC_BYTES];
	logic [CW-1:0]      n;
	logic               full;
	logic               dec_emit;
	kind_t              dec_kind;
	result_t            dec_res;
	logic               status_run;
	logic [7:0]         st_byte;
	logic               s1_emit;
	logic               out_free;
	logic               s1_go;
	logic               s1_done;
	logic               run_last;
	logic               is_dual;

	assign full     = (cnt_q >= CW'(FRAME_BYTES));
	assign n        = full ? cnt_q : cnt_q + CW'(1);
	assign out_free = !m_valid_q || m_tready;
	assign status_run = (last_cmd_q == CMD_STATUS);
	assign run_last   = (rd_idx_q == RW'(STATUS_LEN - 1));

	always_comb begin
		for (int i = 0; i < DEC_BYTES; i++) begin
			nb[i] = (cnt_q == CW'(i)) ? byte_s1 : buf_q[i];
		end
	end

	always_comb begin
		dec_emit = 1'b0;
		dec_kind = KIND_RESET_ENC;
		dec_res  = '0;
		is_dual  = (nb[0] == CMD_MOTOR_DUAL);
		priority if (nb[0] == CMD_MOTOR_DUAL || nb[0] == CMD_MOTOR_ONE ||
				nb[0] == CMD_MOTOR_TWO) begin
			if (n >= CW'(2)) begin
				dec_emit = 1'b1;
				dec_kind = is_dual ? KIND_MOTOR_DUAL :
					(nb[0] == CMD_MOTOR_ONE ? KIND_MOTOR_ONE : KIND_MOTOR_TWO);
				dec_res.ctrl_mode = nb[1];
				if (nb[1] == MODE_SPEED || nb[1] == MODE_POS16) begin
					if (n >= (is_dual ? CW'(6) : CW'(4))) begin
						dec_res.first_short = {nb[2], nb[3]};
						if (is_dual) begin
							dec_res.second_short = {nb[4], nb[5]};
						end
					end
				end else if (nb[1] == MODE_POS32) begin
					if (n >= (is_dual ? CW'(10) : CW'(6))) begin
						dec_res.first_long = {nb[2], nb[3], nb[4], nb[5]};
						if (is_dual) begin
							dec_res.second_long = {nb[6], nb[7], nb[8], nb[9]};
						end
					end
				end
			end
		end else if (nb[0] == CMD_SERVO_DUAL) begin
			if (n >= CW'(3)) begin
				dec_emit = 1'b1;
				dec_kind = KIND_SERVO_DUAL;
				dec_res.first_angle  = nb[1];
				dec_res.second_angle = nb[2];
			end
		end else if (nb[0] == CMD_SERVO_ONE || nb[0] == CMD_SERVO_TWO) begin
			if (n >= CW'(2)) begin
				dec_emit = 1'b1;
				dec_kind = (nb[0] == CMD_SERVO_ONE) ? KIND_SERVO_ONE : KIND_SERVO_TWO;
				dec_res.first_angle = nb[1];
			end
		end else if (nb[0] == CMD_RESET_ENC) begin
			dec_emit = 1'b1;
			dec_kind = KIND_RESET_ENC;
		end else begin
			dec_emit = 1'b0;
		end
	end

	always_comb begin
		unique case (rd_idx_q)
			RW'(0):  st_byte = mpos_q[0][31:24];
			RW'(1):  st_byte = mpos_q[0][23:16];
			RW'(2):  st_byte = mpos_q[0][15:8];
			RW'(3):  st_byte = mpos_q[0][7:0];
			RW'(4):  st_byte = mspd_q[0][15:8];
			RW'(5):  st_byte = mspd_q[0][7:0];
			RW'(6):  st_byte = mmode_q[0];
			RW'(7):  st_byte = mpos_q[1][31:24];
			RW'(8):  st_byte = mpos_q[1][23:16];
			RW'(9):  st_byte = mpos_q[1][15:8];
			RW'(10): st_byte = mpos_q[1][7:0];
			RW'(11): st_byte = mspd_q[1][15:8];
			RW'(12): st_byte = mspd_q[1][7:0];
			RW'(13): st_byte = mmode_q[1];
			default: st_byte = 8'h00;
		endcase
	end

	always_comb begin
		unique case (op_s1)
			OP_WRITE: s1_emit = end_s1 && dec_emit;
			OP_READ:  s1_emit = 1'b1;
			default:  s1_emit = 1'b0;
		endcase
	end

	assign s1_go    = s1_valid_q && (out_free || !s1_emit);
	assign s1_done  = s1_go && !(op_s1 == OP_READ && status_run && !run_last);
	assign s_tready = !s1_valid_q || s1_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser[1:0]);
			sel_s1  <= s_tuser[2];
			end_s1  <= s_tlast;
			byte_s1 <= s_tdata[7:0];
			pos_s1  <= s_tdata[39:8];
			spd_s1  <= s_tdata[55:40];
			mode_s1 <= s_tdata[63:56];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && op_s1 == OP_WRITE && !full) begin
			buf_q[cnt_q[IW-1:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			last_cmd_q <= '0;
			rd_idx_q   <= '0;
			for (int m = 0; m < 2; m++) begin
				mpos_q[m]  <= '0;
				mspd_q[m]  <= '0;
				mmode_q[m] <= '0;
			end
		end else if (s1_go) begin
			unique case (op_s1)
				OP_WRITE: begin
					if (end_s1) begin
						cnt_q      <= '0;
						last_cmd_q <= nb[0];
					end else if (!full) begin
						cnt_q <= cnt_q + CW'(1);
					end
				end
				OP_READ: begin
					if (status_run) begin
						rd_idx_q <= run_last ? '0 : rd_idx_q + RW'(1);
					end
				end
				OP_STATUS: begin
					mpos_q[sel_s1]  <= pos_s1;
					mspd_q[sel_s1]  <= spd_s1;
					mmode_q[sel_s1] <= mode_s1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s1_go && s1_emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_emit) begin
			if (op_s1 == OP_READ) begin
				res_q           <= '0;
				res_q.read_data <= status_run ? st_byte : ERR_BYTE;
				kind_q          <= KIND_READ;
				last_q          <= !status_run || run_last;
			end else begin
				res_q  <= dec_res;
				kind_q <= dec_kind;
				last_q <= 1'b1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = res_q;
	assign m_tuser  = kind_q;
	assign m_tlast  = last_q;

	a_run_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_idx_q != '0) |-> (s1_valid_q && op_s1 == OP_READ && status_run))
		else $error("status run active without a read in the input stage");

	a_run_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_idx_q != '0 && !run_last) |-> !s_tready)
		else $error("input accepted in the middle of a status run");

	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && kind_q != KIND_READ) |-> last_q)
		else $error("command word without tlast");

	a_cnt_sat: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(FRAME_BYTES))
		else $error("frame count beyond buffer size");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=> m_valid_q)
		else $error("result word dropped while stalled");

endmodule

`default_nettype wire

// ----- sim/motor_servo_command_frame_decoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_servo_command_frame_decoder_unit_tb
// Streams write frames, read requests and motor status updates into the
// decoder with random gaps and back-pressure. A predictor of the decoder turns
// every accepted word into the results it should cause; the monitor compares
// each output word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module motor_servo_command_frame_decoder_unit_tb;

	import mscfd_pkg::*;

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int TAIL_CYCLES = 40;
	localparam int RAND_WORDS  = 500;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  rx;
		logic        fend;
		logic        motor;
		logic [31:0] pos;
		logic [15:0] spd;
		logic [7:0]  mode;
		bit          drain;
	} word_t;

	typedef struct {
		kind_t   kind;
		result_t data;
		logic    last;
	} reply_t;

	typedef logic [7:0] frame_q_t [$];

	logic         clk      = 1'b0;
	logic         arst_n   = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [63:0]  s_tdata  = '0;
	logic [2:0]   s_tuser  = '0;
	logic         s_tlast  = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	word_t  word_q [$];
	reply_t reply_q [$];
	word_t  held_word;
	logic   word_taken = 1'b0;
	int     send_gap = 0;
	int     hold_cnt = 0;
	int     cycle_cnt = 0;
	int     words_total = 0;
	int     words_taken = 0;
	int     errors = 0;

	// predictor state
	logic [7:0]  fbuf [FRAME_BYTES];
	int unsigned fill = 0;
	logic [7:0]  last_cmd = '0;
	logic [31:0] mpos [2];
	logic [15:0] mspd [2];
	logic [7:0]  mmode [2];

	motor_servo_command_frame_decoder_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// gap length; every fourth window of the cycle counter runs without gaps
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if ((cycle_cnt / 1024) % 4 == 3 || r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic reply_t blank_reply(kind_t kind);
		reply_t rep;
		rep.kind = kind;
		rep.data = '0;
		rep.last = 1'b1;
		return rep;
	endfunction

	task automatic decode_word(input word_t w);
		reply_t      rep;
		logic [7:0]  cmd;
		int unsigned n;
		bit          dual;
		bit          emit;
		logic [7:0]  stat [7];
		case (w.op)
			OP_WRITE: begin
				if (fill < FRAME_BYTES) begin
					fbuf[fill] = w.rx;
					fill++;
				end
				if (w.fend) begin
					n = fill;
					fill = 0;
					cmd = fbuf[0];
					last_cmd = cmd;
					emit = 1'b0;
					rep = blank_reply(KIND_RESET_ENC);
					if (cmd == CMD_MOTOR_DUAL || cmd == CMD_MOTOR_ONE || cmd == CMD_MOTOR_TWO) begin
						dual = (cmd == CMD_MOTOR_DUAL);
						if (n >= 2) begin
							emit = 1'b1;
							if (dual)
								rep.kind = KIND_MOTOR_DUAL;
							else if (cmd == CMD_MOTOR_ONE)
								rep.kind = KIND_MOTOR_ONE;
							else
								rep.kind = KIND_MOTOR_TWO;
							rep.data.ctrl_mode = fbuf[1];
							if (fbuf[1] == MODE_SPEED || fbuf[1] == MODE_POS16) begin
								if (n >= (dual ? 6 : 4)) begin
									rep.data.first_short = {fbuf[2], fbuf[3]};
									if (dual)
										rep.data.second_short = {fbuf[4], fbuf[5]};
								end
							end else if (fbuf[1] == MODE_POS32) begin
								if (n >= (dual ? 10 : 6)) begin
									rep.data.first_long = {fbuf[2], fbuf[3], fbuf[4], fbuf[5]};
									if (dual)
										rep.data.second_long = {fbuf[6], fbuf[7], fbuf[8], fbuf[9]};
								end
							end
						end
					end else if (cmd == CMD_SERVO_DUAL) begin
						if (n >= 3) begin
							emit = 1'b1;
							rep.kind = KIND_SERVO_DUAL;
							rep.data.first_angle = fbuf[1];
							rep.data.second_angle = fbuf[2];
						end
					end else if (cmd == CMD_SERVO_ONE || cmd == CMD_SERVO_TWO) begin
						if (n >= 2) begin
							emit = 1'b1;
							if (cmd == CMD_SERVO_ONE)
								rep.kind = KIND_SERVO_ONE;
							else
								rep.kind = KIND_SERVO_TWO;
							rep.data.first_angle = fbuf[1];
						end
					end else if (cmd == CMD_RESET_ENC) begin
						emit = 1'b1;
					end
					if (emit)
						reply_q.push_back(rep);
				end
			end
			OP_READ: begin
				if (last_cmd == CMD_STATUS) begin
					for (int m = 0; m < 2; m++) begin
						stat = '{mpos[m][31:24], mpos[m][23:16], mpos[m][15:8], mpos[m][7:0],
							mspd[m][15:8], mspd[m][7:0], mmode[m]};
						for (int k = 0; k < 7; k++) begin
							rep = blank_reply(KIND_READ);
							rep.data.read_data = stat[k];
							rep.last = (m == 1 && k == 6);
							reply_q.push_back(rep);
						end
					end
				end else begin
					rep = blank_reply(KIND_READ);
					rep.data.read_data = ERR_BYTE;
					reply_q.push_back(rep);
				end
			end
			OP_STATUS: begin
				mpos[w.motor] = w.pos;
				mspd[w.motor] = w.spd;
				mmode[w.motor] = w.mode;
			end
			default: begin
			end
		endcase
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	task automatic check_reply();
		reply_t  want;
		result_t got;
		got = result_t'(m_tdata);
		if (reply_q.size() == 0) begin
			$display("%0t: unexpected word kind %0d data %h", $time, m_tuser, m_tdata);
			errors++;
		end else begin
			want = reply_q.pop_front();
			cmp_field("out_kind", 32'(want.kind), 32'(m_tuser));
			cmp_field("ctrl_mode", 32'(want.data.ctrl_mode), 32'(got.ctrl_mode));
			cmp_field("first_short", 32'(want.data.first_short), 32'(got.first_short));
			cmp_field("first_long", want.data.first_long, got.first_long);
			cmp_field("second_short", 32'(want.data.second_short), 32'(got.second_short));
			cmp_field("second_long", want.data.second_long, got.second_long);
			cmp_field("first_angle", 32'(want.data.first_angle), 32'(got.first_angle));
			cmp_field("second_angle", 32'(want.data.second_angle), 32'(got.second_angle));
			cmp_field("read_data", 32'(want.data.read_data), 32'(got.read_data));
			cmp_field("last_of_run", 32'(want.last), 32'(m_tlast));
		end
	endtask

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		word_taken <= s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready)
			check_reply();
		if (arst_n && s_tvalid && s_tready) begin
			decode_word(held_word);
			words_taken++;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || word_taken) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (word_q.size() == 0 || (word_q[0].drain && reply_q.size() != 0)) begin
				s_tvalid <= 1'b0;
			end else begin
				held_word <= word_q[0];
				s_tdata <= {word_q[0].mode, word_q[0].spd, word_q[0].pos, word_q[0].rx};
				s_tuser <= {word_q[0].motor, word_q[0].op};
				s_tlast <= word_q[0].fend;
				s_tvalid <= 1'b1;
				void'(word_q.pop_front());
				send_gap = idle_len();
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cnt > 0) begin
			m_tready <= 1'b0;
			hold_cnt--;
		end else begin
			m_tready <= 1'b1;
			hold_cnt = idle_len();
		end
	end

	// unused fields carry random junk
	function automatic word_t rand_word(logic [1:0] op);
		word_t w;
		w.op = op;
		w.rx = 8'($urandom_range(0, 255));
		w.fend = 1'($urandom_range(0, 1));
		w.motor = 1'($urandom_range(0, 1));
		w.pos = $urandom;
		w.spd = 16'($urandom_range(0, 65535));
		w.mode = 8'($urandom_range(0, 255));
		w.drain = 1'b0;
		return w;
	endfunction

	task automatic push_word(input word_t w);
		word_q.push_back(w);
		words_total++;
	endtask

	task automatic push_frame(input frame_q_t fb);
		word_t w;
		foreach (fb[i]) begin
			w = rand_word(OP_WRITE);
			w.rx = fb[i];
			w.fend = (i == fb.size() - 1);
			push_word(w);
		end
	endtask

	task automatic push_read(input bit drain);
		word_t w;
		w = rand_word(OP_READ);
		w.drain = drain;
		push_word(w);
	endtask

	task automatic push_status(input logic m, input logic [31:0] pos, input logic [15:0] spd,
		input logic [7:0] mode);
		word_t w;
		w = rand_word(OP_STATUS);
		w.motor = m;
		w.pos = pos;
		w.spd = spd;
		w.mode = mode;
		push_word(w);
	endtask

	task automatic push_rand_frame();
		frame_q_t   fb;
		logic [7:0] cmd;
		logic [7:0] mode;
		int         r;
		int         len;
		bit         motor;
		r = $urandom_range(0, 99);
		if (r < 20)      cmd = CMD_MOTOR_DUAL;
		else if (r < 32) cmd = CMD_MOTOR_ONE;
		else if (r < 44) cmd = CMD_MOTOR_TWO;
		else if (r < 56) cmd = CMD_SERVO_DUAL;
		else if (r < 66) cmd = CMD_SERVO_ONE;
		else if (r < 74) cmd = CMD_SERVO_TWO;
		else if (r < 80) cmd = CMD_RESET_ENC;
		else if (r < 88) cmd = CMD_STATUS;
		else             cmd = 8'($urandom_range(0, 255));
		mode = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 2)) :
			8'($urandom_range(0, 255));
		motor = (cmd == CMD_MOTOR_DUAL || cmd == CMD_MOTOR_ONE || cmd == CMD_MOTOR_TWO);
		if (motor) begin
			if (mode == MODE_SPEED || mode == MODE_POS16)
				len = (cmd == CMD_MOTOR_DUAL) ? 6 : 4;
			else if (mode == MODE_POS32)
				len = (cmd == CMD_MOTOR_DUAL) ? 10 : 6;
			else
				len = 2;
		end else if (cmd == CMD_SERVO_DUAL) begin
			len = 3;
		end else if (cmd == CMD_SERVO_ONE || cmd == CMD_SERVO_TWO) begin
			len = 2;
		end else if (cmd == CMD_RESET_ENC || cmd == CMD_STATUS) begin
			len = 1;
		end else begin
			len = $urandom_range(1, 4);
		end
		if ($urandom_range(0, 3) == 0)
			len = $urandom_range(1, 13);
		fb.push_back(cmd);
		for (int i = 1; i < len; i++)
			fb.push_back((motor && i == 1) ? mode : 8'($urandom_range(0, 255)));
		push_frame(fb);
	endtask

	initial begin
		int r;
		foreach (fbuf[i])
			fbuf[i] = '0;
		for (int m = 0; m < 2; m++) begin
			mpos[m] = '0;
			mspd[m] = '0;
			mmode[m] = '0;
		end

		push_read(1'b0);
		push_status(1'b0, 32'h8000_0000, 16'h7FFF, 8'hFF);
		push_status(1'b1, 32'h7FFF_FFFF, 16'h8000, 8'h00);
		push_frame({CMD_STATUS});
		push_read(1'b1);
		// full dual 32-bit frame plus one byte past the buffer
		push_frame({CMD_MOTOR_DUAL, MODE_POS32, 8'hFF, 8'h00, 8'h80, 8'h01,
			8'h7F, 8'hFF, 8'hFF, 8'h80, 8'hAA});
		push_frame({CMD_MOTOR_ONE, MODE_POS16, 8'h80, 8'h00});
		push_frame({CMD_MOTOR_DUAL, MODE_SPEED, 8'h12});
		push_frame({CMD_MOTOR_TWO, 8'h05});
		push_frame({CMD_SERVO_DUAL, 8'h80, 8'h7F});
		push_frame({CMD_SERVO_TWO, 8'hFF});
		push_frame({CMD_RESET_ENC});
		push_frame({CMD_MOTOR_DUAL});
		push_frame({CMD_SERVO_ONE});
		push_frame({8'h99});
		push_word(rand_word(OP_UNUSED));
		push_read(1'b1);

		while (words_total < RAND_WORDS + 30) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				push_rand_frame();
			else if (r < 75)
				push_read($urandom_range(0, 99) == 0);
			else if (r < 88)
				push_status(1'($urandom_range(0, 1)), $urandom, 16'($urandom_range(0, 65535)),
					8'($urandom_range(0, 255)));
			else
				push_word(rand_word(2'($urandom_range(0, 3))));
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_taken != words_total)
			@(posedge clk);
		while (reply_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("%0t: timeout, %0d results outstanding", $time, reply_q.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mscfd_pkg.sv
rtl/core/motor_servo_command_frame_decoder_unit.sv
sim/motor_servo_command_frame_decoder_unit_tb.sv
